// ===== rtl/lock_table_manager_defines.svh =====
// assertion macros shared by the lock table rtl
// expects signals named clock and reset in the including module
`ifndef LOCK_TABLE_MANAGER_DEFINES_SVH
`define LOCK_TABLE_MANAGER_DEFINES_SVH

// same-cycle implication, inactive during reset
`define LTM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, inactive during reset
`define LTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ltm_pkg.sv =====
// types and constants for the lock table manager
// no dependencies
package ltm_pkg;

   localparam int COMMAND_WIDTH = 3;
   localparam int OWNER_WIDTH   = 16;
   localparam int KEY_WIDTH     = 64;

   localparam int DEF_ENTRIES    = 128;
   localparam int DEF_KEY_BITS   = 64;
   localparam int DEF_OWNER_BITS = 16;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_TRY_LOCK     = 3'd0,
      CMD_UNLOCK_KEY   = 3'd1,
      CMD_UNLOCK_OWNER = 3'd2,
      CMD_CHECK_OWNER  = 3'd3,
      CMD_CHECK_KEY    = 3'd4,
      CMD_CHECK_PAIR   = 3'd5
   } command_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_WRITE
   } state_type;

endpackage

// ===== rtl/ltm_req_if.sv =====
// request channel of the lock table manager
// depends on ltm_pkg
interface ltm_req_if import ltm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COMMAND_WIDTH-1:0] command;
   logic [OWNER_WIDTH-1:0]   owner;
   logic [KEY_WIDTH-1:0]     key;

   modport source (output valid, output command, output owner, output key, input ready);
   modport sink   (input valid, input command, input owner, input key, output ready);
endinterface

// ===== rtl/ltm_rsp_if.sv =====
// response channel of the lock table manager
// depends on ltm_pkg
interface ltm_rsp_if import ltm_pkg::*; ();
   logic valid;
   logic ready;
   logic answer;

   modport source (output valid, output answer, input ready);
   modport sink   (input valid, input answer, output ready);
endinterface

// ===== rtl/lock_table_manager.sv =====
// lock table manager: table memory, scan sequencer and response register
// depends on ltm_pkg, ltm_req_if, ltm_rsp_if and lock_table_manager_defines.svh
`include "lock_table_manager_defines.svh"

// A table of ENTRIES named locks held in one single-port-write synchronous
// memory, each word holding a valid flag, an owner and a key. Every request
// scans the whole memory once, one entry per cycle, keeping the lowest
// matching entry and the lowest free entry, then writes back at most one
// word. Requests are served one at a time: the scan, a last-entry step and
// the write-back with the response load finish before the next acceptance;
// the single read port of the table sets the scan's pace. After reset a
// clearing pass marks every entry free, during which no request is taken.
// A finished response waits in its own register and the next request is
// accepted while it waits; the next write-back stalls until it is taken.
module lock_table_manager
   import ltm_pkg::*;
#(
   parameter int ENTRIES    = DEF_ENTRIES,
   parameter int KEY_BITS   = DEF_KEY_BITS,
   parameter int OWNER_BITS = DEF_OWNER_BITS
) (
   input logic        clock,
   input logic        reset,
   ltm_req_if.sink    req_chan,
   ltm_rsp_if.source  rsp_chan
);

   localparam int AW = $clog2(ENTRIES);
   localparam int WW = 1 + OWNER_BITS + KEY_BITS;
   localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [WW-1:0] table_ff [ENTRIES];
   logic [WW-1:0] rd_data_ff;

   logic [AW-1:0]         scan_addr_ff, scan_addr_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   command_type           cmd_ff, cmd_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic                  hit_found_ff, hit_found_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic                  free_found_ff, free_found_in;
   logic [AW-1:0]         free_idx_ff, free_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_answer_ff, rsp_answer_in;

   logic          req_fire;
   logic          by_owner, by_key, key_nonzero;
   logic          entry_valid, entry_hit;
   logic          out_load, do_write, answer;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [WW-1:0] mem_wdata;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.answer = rsp_answer_ff;
   assign key_nonzero     = (key_ff != '0);

   // match criteria per command
   always_comb begin
      by_owner = 1'b0;
      by_key   = 1'b0;
      case (cmd_ff)
         CMD_TRY_LOCK:     by_key   = 1'b1;
         CMD_UNLOCK_KEY:   by_key   = 1'b1;
         CMD_UNLOCK_OWNER: by_owner = 1'b1;
         CMD_CHECK_OWNER:  by_owner = 1'b1;
         CMD_CHECK_KEY:    by_key   = 1'b1;
         CMD_CHECK_PAIR: begin
            by_owner = 1'b1;
            by_key   = 1'b1;
         end
         default: begin
            by_owner = 1'b0;
            by_key   = 1'b0;
         end
      endcase
   end

   assign entry_valid = rd_data_ff[WW-1];
   assign entry_hit   = entry_valid
                      && (!by_owner || (rd_data_ff[KEY_BITS +: OWNER_BITS] == owner_ff))
                      && (!by_key || (rd_data_ff[KEY_BITS-1:0] == key_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (scan_addr_ff == LAST_ADDR) state_in = ST_IDLE;
         ST_IDLE:  if (req_chan.valid) state_in = ST_SCAN;
         ST_SCAN:  if (scan_addr_ff == LAST_ADDR) state_in = ST_LAST;
         ST_LAST:  state_in = ST_WRITE;
         ST_WRITE: if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // write-back decision on the scan summary
   always_comb begin
      do_write = 1'b0;
      answer   = 1'b0;
      case (cmd_ff)
         CMD_TRY_LOCK: begin
            do_write = key_nonzero && !hit_found_ff && free_found_ff;
            answer   = do_write;
         end
         CMD_UNLOCK_KEY:   do_write = key_nonzero && hit_found_ff;
         CMD_UNLOCK_OWNER: do_write = hit_found_ff;
         CMD_CHECK_OWNER:  answer   = hit_found_ff;
         CMD_CHECK_KEY:    answer   = key_nonzero && hit_found_ff;
         CMD_CHECK_PAIR:   answer   = key_nonzero && hit_found_ff;
         default: begin
            do_write = 1'b0;
            answer   = 1'b0;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      out_load       = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = scan_addr_ff;
      mem_wdata      = '0;
      case (state_ff)
         ST_CLEAR: mem_we = 1'b1;
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_WRITE: begin
            out_load = !rsp_valid_ff || rsp_chan.ready;
            mem_we   = out_load && do_write;
            if (cmd_ff == CMD_TRY_LOCK) begin
               mem_waddr = free_idx_ff;
               mem_wdata = {1'b1, owner_ff, key_ff};
            end else begin
               mem_waddr = hit_idx_ff;
               mem_wdata = {1'b0, owner_ff, key_ff};
            end
         end
         default: begin
            req_chan.ready = 1'b0;
            out_load       = 1'b0;
            mem_we         = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      scan_addr_in  = scan_addr_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = scan_addr_ff;
      cmd_in        = cmd_ff;
      owner_in      = owner_ff;
      key_in        = key_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;

      if (state_ff == ST_CLEAR || state_ff == ST_SCAN) begin
         scan_addr_in = scan_addr_ff + AW'(1);
      end
      if (state_ff == ST_SCAN) begin
         rd_pend_in = 1'b1;
      end

      if (rd_pend_ff) begin
         if (!hit_found_ff && entry_hit) begin
            hit_found_in = 1'b1;
            hit_idx_in   = rd_idx_ff;
         end
         if (!free_found_ff && !entry_valid) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (req_fire) begin
         cmd_in        = command_type'(req_chan.command);
         owner_in      = OWNER_BITS'(req_chan.owner);
         key_in        = KEY_BITS'(req_chan.key);
         scan_addr_in  = '0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_answer_in = rsp_answer_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_answer_in = answer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         scan_addr_ff  <= '0;
         rd_pend_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_addr_ff  <= scan_addr_in;
         rd_pend_ff    <= rd_pend_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cmd_ff        <= cmd_in;
      owner_ff      <= owner_in;
      key_ff        <= key_in;
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   // lock table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_ff[scan_addr_ff];
   end

   `LTM_ASSERT_NEXT(a_accept_starts_scan, req_fire, state_ff == ST_SCAN, "accept did not start a scan")
   `LTM_ASSERT_IMPLIES(a_no_write_in_scan, state_ff == ST_SCAN || state_ff == ST_LAST, !mem_we, "table written during scan")
   `LTM_ASSERT_IMPLIES(a_grant_needs_free, mem_we && state_ff == ST_WRITE && mem_wdata[WW-1], free_found_ff && !hit_found_ff, "lock granted without a free entry or with key held")
   `LTM_ASSERT_IMPLIES(a_no_accept_in_clear, state_ff == ST_CLEAR, !req_chan.ready, "request accepted during clearing pass")
   `LTM_ASSERT_NEXT(a_load_gives_rsp, out_load, rsp_valid_ff, "response register not loaded")

endmodule
